@@ rtl/core/sdhs_pkg.sv @@
// Shared constants, types and cell operation codes for the SCAN disk head scheduler.
`timescale 1ns / 1ps
`default_nettype none

package sdhs_pkg;

    // Default sizing of the request store and of cylinder numbers.
    localparam int DEF_MAX_REQUESTS  = 32;
    localparam int DEF_POSITION_BITS = 16;

    // Width of the running seek total and of the average.
    localparam int TOTAL_W = 22;

    // Configuration port layout.
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_END_POSITION   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_POSITION = 1'd1;

    localparam logic [CFG_W-1:0] END_POSITION_RESET   = 16'd199;
    localparam logic [CFG_W-1:0] START_POSITION_RESET = 16'd0;

    // Operation applied to every cell of a chain in the same cycle.
    typedef logic [1:0] cell_op_t;

    localparam cell_op_t OP_HOLD       = 2'd0;
    localparam cell_op_t OP_INSERT     = 2'd1;
    localparam cell_op_t OP_PUSH       = 2'd2;
    localparam cell_op_t OP_SHIFT_DOWN = 2'd3;

endpackage

`default_nettype wire

@@ rtl/core/sdhs_cell.sv @@
// One cell of a request chain: holds a single cylinder value and its valid flag.
`timescale 1ns / 1ps
`default_nettype none

module sdhs_cell
    import sdhs_pkg::*;
#(
    parameter int WIDTH = DEF_POSITION_BITS
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_op_t         op,
    input  wire logic [WIDTH-1:0] new_value,
    input  wire logic [WIDTH-1:0] lower_value,
    input  wire logic             lower_valid,
    input  wire logic             lower_greater,
    input  wire logic [WIDTH-1:0] upper_value,
    input  wire logic             upper_valid,
    output logic [WIDTH-1:0]      value,
    output logic                  valid,
    output logic                  greater
);

    logic [WIDTH-1:0] value_reg;
    logic [WIDTH-1:0] value_next;
    logic             valid_reg;
    logic             valid_next;

    // An empty cell counts as greater than any new value.
    assign greater = !valid_reg || (value_reg > new_value);
    assign value   = value_reg;
    assign valid   = valid_reg;

    // Insertion keeps values not greater than the new one in place and moves the rest up by one cell.
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        unique case (op)
            OP_HOLD:
            begin
                value_next = value_reg;
            end
            OP_INSERT:
            begin
                if (greater)
                begin
                    value_next = lower_greater ? lower_value : new_value;
                    valid_next = valid_reg | lower_valid;
                end
            end
            OP_PUSH:
            begin
                value_next = lower_value;
                valid_next = lower_valid;
            end
            OP_SHIFT_DOWN:
            begin
                value_next = upper_value;
                valid_next = upper_valid;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/sdhs_chain.sv @@
// Row of cells that forms a sorted request store or a last-in first-out stack.
`timescale 1ns / 1ps
`default_nettype none

module sdhs_chain
    import sdhs_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_REQUESTS,
    parameter int WIDTH = DEF_POSITION_BITS
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_op_t         op,
    input  wire logic [WIDTH-1:0] new_value,
    output logic [WIDTH-1:0]      head_value,
    output logic                  head_valid
);

    logic [WIDTH-1:0] cell_value   [DEPTH];
    logic             cell_valid   [DEPTH];
    logic             cell_greater [DEPTH];

    // Each cell sees its lower and upper neighbour; the ends see the new value or an empty cell.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WIDTH-1:0] lower_value;
        logic             lower_valid;
        logic             lower_greater;
        logic [WIDTH-1:0] upper_value;
        logic             upper_valid;

        if (i == 0)
        begin : g_first
            assign lower_value   = new_value;
            assign lower_valid   = 1'b1;
            assign lower_greater = 1'b0;
        end
        else
        begin : g_inner_low
            assign lower_value   = cell_value[i-1];
            assign lower_valid   = cell_valid[i-1];
            assign lower_greater = cell_greater[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper_value = '0;
            assign upper_valid = 1'b0;
        end
        else
        begin : g_inner_high
            assign upper_value = cell_value[i+1];
            assign upper_valid = cell_valid[i+1];
        end

        sdhs_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .op            (op),
            .new_value     (new_value),
            .lower_value   (lower_value),
            .lower_valid   (lower_valid),
            .lower_greater (lower_greater),
            .upper_value   (upper_value),
            .upper_valid   (upper_valid),
            .value         (cell_value[i]),
            .valid         (cell_valid[i]),
            .greater       (cell_greater[i])
        );
    end

    assign head_value = cell_value[0];
    assign head_valid = cell_valid[0];

endmodule

`default_nettype wire

@@ rtl/core/sdhs_div.sv @@
// Restoring divider for the average seek, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sdhs_div
#(
    parameter int DIVIDEND_W = 22,
    parameter int DIVISOR_W  = 6
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits      = rem_shift >= {1'b0, divisor_reg};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/scan_disk_head_scheduler.sv @@
// Requests load into a sorted chain of cells; while there is room, each is inserted as it is accepted.
// After the marked request, each request below the head is pushed onto a stack, the turn after
// the upward sweep passes through an idle step, and each move beat is issued when the output is free.
// The final move is held back while the bit-serial divider works out the average.
// One request is taken per cycle while loading; no request is taken while a schedule runs.
// Reset: control, counts and valid flags clear; end position is 199 and start position 0.
`timescale 1ns / 1ps
`default_nettype none

module scan_disk_head_scheduler
    import sdhs_pkg::*;
#(
    parameter int MAX_REQUESTS  = DEF_MAX_REQUESTS,
    parameter int POSITION_BITS = DEF_POSITION_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration write port.
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    // Request stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // s_tdata fields from bit 0: request_position.
    input  wire logic [((POSITION_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  wire logic                   s_tlast,
    // Move stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // m_tdata fields from bit 0: from_position, to_position, move_distance,
    // total_seek, average_seek.
    output logic [((3 * POSITION_BITS + 2 * TOTAL_W + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                        m_tlast
);

    localparam int P          = POSITION_BITS;
    localparam int CNT_W      = $clog2(MAX_REQUESTS + 1);
    localparam int OUT_DATA_W = ((3 * P + 2 * TOTAL_W + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_REQUESTS);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_DRAIN = 3'd1;
    localparam logic [2:0] ST_END   = 3'd2;
    localparam logic [2:0] ST_POP   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;

    localparam logic [P+CFG_W-1:0] END_RESET_WIDE   = {{P{1'b0}}, END_POSITION_RESET};
    localparam logic [P+CFG_W-1:0] START_RESET_WIDE = {{P{1'b0}}, START_POSITION_RESET};

    // Configuration registers.
    logic [P-1:0]       end_reg;
    logic [P-1:0]       start_reg;
    logic [P+CFG_W-1:0] cfg_wide;

    // Control state.
    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   n_next;
    logic [CNT_W-1:0]   stack_cnt_reg;
    logic [CNT_W-1:0]   stack_cnt_next;
    logic [P-1:0]       head_reg;
    logic [P-1:0]       head_next;
    logic [P-1:0]       cur_reg;
    logic [P-1:0]       cur_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    // Output payload.
    logic [P-1:0]       out_from_reg;
    logic [P-1:0]       out_from_next;
    logic [P-1:0]       out_to_reg;
    logic [P-1:0]       out_to_next;
    logic [P-1:0]       out_dist_reg;
    logic [P-1:0]       out_dist_next;
    logic [TOTAL_W-1:0] out_total_reg;
    logic [TOTAL_W-1:0] out_total_next;
    logic [TOTAL_W-1:0] out_avg_reg;
    logic [TOTAL_W-1:0] out_avg_next;
    logic               out_last_reg;
    logic               out_last_next;

    // Chains, divider and move arithmetic.
    cell_op_t           sort_op;
    cell_op_t           stack_op;
    logic [P-1:0]       sort_head_value;
    logic               sort_head_valid;
    logic [P-1:0]       stack_head_value;
    logic               stack_head_valid;
    logic               div_start;
    logic               div_done;
    logic [TOTAL_W-1:0] div_quotient;

    logic               s_accept;
    logic               room;
    logic               out_free;
    logic [P-1:0]       batch_head;
    logic               emit;
    logic               emit_last;
    logic [P-1:0]       emit_to;
    logic [P-1:0]       emit_dist;
    logic [P+TOTAL_W-1:0] dist_wide;
    logic [TOTAL_W-1:0] emit_total;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign room     = (count_reg < MAX_COUNT);
    assign out_free = !out_valid_reg || m_tready;

    // The head never starts beyond the turn-around cylinder.
    assign batch_head = (start_reg > end_reg) ? end_reg : start_reg;

    // Configuration writes.
    assign cfg_wide = {{P{1'b0}}, cfg_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_reg   <= END_RESET_WIDE[P-1:0];
            start_reg <= START_RESET_WIDE[P-1:0];
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_END_POSITION:   end_reg   <= cfg_wide[P-1:0];
                CFG_START_POSITION: start_reg <= cfg_wide[P-1:0];
            endcase
        end
    end

    // Sorted request store and the stack of requests below the head.
    sdhs_chain #(
        .DEPTH (MAX_REQUESTS),
        .WIDTH (P)
    ) u_sort_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (sort_op),
        .new_value  (s_tdata[P-1:0]),
        .head_value (sort_head_value),
        .head_valid (sort_head_valid)
    );

    sdhs_chain #(
        .DEPTH (MAX_REQUESTS),
        .WIDTH (P)
    ) u_stack_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (stack_op),
        .new_value  (sort_head_value),
        .head_value (stack_head_value),
        .head_valid (stack_head_valid)
    );

    sdhs_div #(
        .DIVIDEND_W (TOTAL_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (emit_total),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Distance and running total of the move being issued.
    assign emit_dist  = (emit_to >= cur_reg) ? (emit_to - cur_reg) : (cur_reg - emit_to);
    assign dist_wide  = {{TOTAL_W{1'b0}}, emit_dist};
    assign emit_total = total_reg + dist_wide[TOTAL_W-1:0];
    assign div_start  = emit && emit_last;

    // Sequencer: load, sweep up, turn at the end, sweep down when requests were stacked, then the average.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        stack_cnt_next = stack_cnt_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_from_next  = out_from_reg;
        out_to_next    = out_to_reg;
        out_dist_next  = out_dist_reg;
        out_total_next = out_total_reg;
        out_avg_next   = out_avg_reg;
        out_last_next  = out_last_reg;
        sort_op        = OP_HOLD;
        stack_op       = OP_HOLD;
        emit           = 1'b0;
        emit_last      = 1'b0;
        emit_to        = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_accept)
                begin
                    if (room)
                    begin
                        sort_op    = OP_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                    if (s_tlast)
                    begin
                        n_next     = count_reg + {{(CNT_W - 1){1'b0}}, room};
                        count_next = '0;
                        head_next  = batch_head;
                        cur_next   = batch_head;
                        total_next = '0;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!sort_head_valid)
                begin
                    state_next = ST_END;
                end
                else if (sort_head_value < head_reg)
                begin
                    sort_op        = OP_SHIFT_DOWN;
                    stack_op       = OP_PUSH;
                    stack_cnt_next = stack_cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    emit    = 1'b1;
                    emit_to = (sort_head_value > end_reg) ? end_reg : sort_head_value;
                    sort_op = OP_SHIFT_DOWN;
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_to    = end_reg;
                    emit_last  = (stack_cnt_reg == '0);
                    state_next = emit_last ? ST_DIV : ST_POP;
                end
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    emit_to        = stack_head_value;
                    stack_op       = OP_SHIFT_DOWN;
                    stack_cnt_next = stack_cnt_reg - 1'b1;
                    emit_last      = (stack_cnt_reg == CNT_W'(1));
                    if (emit_last)
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    out_avg_next   = (n_reg == '0) ? '0 : div_quotient;
                    out_valid_next = 1'b1;
                    total_next     = '0;
                    cur_next       = batch_head;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // The final move is held back until its average is known.
        if (emit)
        begin
            out_from_next  = cur_reg;
            out_to_next    = emit_to;
            out_dist_next  = emit_dist;
            out_total_next = emit_total;
            out_avg_next   = '0;
            out_last_next  = emit_last;
            out_valid_next = !emit_last;
            cur_next       = emit_to;
            total_next     = emit_total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            n_reg         <= '0;
            stack_cnt_reg <= '0;
            head_reg      <= '0;
            cur_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            stack_cnt_reg <= stack_cnt_next;
            head_reg      <= head_next;
            cur_reg       <= cur_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_from_reg  <= out_from_next;
        out_to_reg    <= out_to_next;
        out_dist_reg  <= out_dist_next;
        out_total_reg <= out_total_next;
        out_avg_reg   <= out_avg_next;
        out_last_reg  <= out_last_next;
    end

    // Output beat.
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_DATA_W'({out_avg_reg, out_total_reg, out_dist_reg,
                                   out_to_reg, out_from_reg});

`ifndef NO_ASSERTIONS
    // No beat is offered while the average of the final move is being worked out.
    a_no_beat_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> !m_tvalid)
        else $error("move beat offered during average division");

    // The turn-around move is issued only once the sorted store has fully drained.
    a_sort_empty_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_END) |-> !sort_head_valid)
        else $error("sorted store not empty at the turn-around");

    // The downward sweep always has a stacked request to serve.
    a_stack_filled_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> (stack_head_valid && (stack_cnt_reg != '0)))
        else $error("downward sweep with an empty stack");

    // A new batch begins with an empty stack.
    a_stack_empty_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (!stack_head_valid && (stack_cnt_reg == '0)))
        else $error("stack not empty while loading requests");

    // The divider finishes only while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the average phase");
`endif

endmodule

`default_nettype wire
